// ===== src/first_fit_block_allocator_assert.svh =====
// Assertion macros for the first-fit block allocator.
// Used by the top level only; relies on clk and arst_n in the including scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define FFA_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("first_fit_block_allocator: assertion failed");
// next-cycle implication
`define FFA_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("first_fit_block_allocator: assertion failed");
`else
`define FFA_ASSERT_IMP(label, ante, cons)
`define FFA_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== src/ffa_pkg.sv =====
// Shared constants, codes and types of the first-fit block allocator.
// No dependencies; used by ffa_ctrl, ffa_datapath and the top level.
`default_nettype none
package ffa_pkg;

	// arena geometry (ALIGN_BYTES is a power of two)
	localparam int ARENA_BYTES  = 1024;
	localparam int ALIGN_BYTES  = 16;
	localparam int HEADER_BYTES = 16;

	localparam int ALIGN_LOG2 = $clog2(ALIGN_BYTES);
	localparam int NGRAN      = ARENA_BYTES / ALIGN_BYTES;
	localparam int HDR_G      = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int HDR_BYTES  = HDR_G * ALIGN_BYTES;
	localparam int GW         = $clog2(NGRAN);
	localparam int PW         = 17 - ALIGN_LOG2;
	localparam int CW         = ((GW > PW) ? GW : PW) + 2;

	// port widths
	localparam int KIND_W = 2;
	localparam int REQ_W  = 16;
	localparam int OFF_W  = 10;
	localparam int ST_W   = 2;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;

	// result status codes
	localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
	localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
	localparam logic [ST_W-1:0] ST_BADADDR = 2'd2;

	// one block header as stored per granule
	typedef struct packed {
		logic          present;
		logic          used;
		logic [GW-1:0] size;
	} entry_t;

	localparam entry_t ENTRY_ARENA  = '{present: 1'b1, used: 1'b0,
		size: GW'(NGRAN - HDR_G)};
	localparam entry_t ENTRY_ABSENT = '{present: 1'b0, used: 1'b0, size: '0};

	// controller to datapath
	typedef struct packed {
		logic            load;
		logic            rd_cur;
		logic            step;
		logic            wr_grant;
		logic            wr_split;
		logic            wr_free;
		logic            clear;
		logic            emit;
		logic [ST_W-1:0] st;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic present;
		logic fits;
		logic split_ok;
		logic next_oob;
		logic free_bad;
	} stat_t;

endpackage
`default_nettype wire

// ===== src/ffa_ctrl.sv =====
// Controller of the first-fit block allocator: sequences walk, free and restart.
// Depends on ffa_pkg.
`default_nettype none
module ffa_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [ffa_pkg::KIND_W-1:0] kind,
	input  wire ffa_pkg::stat_t            stat,
	output ffa_pkg::cmd_t                  cmd,
	output logic                           busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ARD   = 3'd1;
	localparam logic [2:0] S_AEV   = 3'd2;
	localparam logic [2:0] S_SPLIT = 3'd3;
	localparam logic [2:0] S_FCHK  = 3'd4;
	localparam logic [2:0] S_FEV   = 3'd5;
	localparam logic [2:0] S_RST   = 3'd6;

	logic [2:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (kind == ffa_pkg::KIND_ALLOC)
						state_d = S_ARD;
					else if (kind == ffa_pkg::KIND_FREE)
						state_d = S_FCHK;
					else
						state_d = S_RST;
				end
			end
			S_ARD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_AEV;
			end
			S_AEV: begin
				if (!stat.present) begin
					cmd.emit = 1'b1;
					cmd.st   = ffa_pkg::ST_NOSPACE;
					state_d  = S_IDLE;
				end else if (stat.fits) begin
					cmd.wr_grant = 1'b1;
					cmd.emit     = 1'b1;
					cmd.st       = ffa_pkg::ST_DONE;
					state_d      = stat.split_ok ? S_SPLIT : S_IDLE;
				end else if (stat.next_oob) begin
					cmd.emit = 1'b1;
					cmd.st   = ffa_pkg::ST_NOSPACE;
					state_d  = S_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_SPLIT: begin
				cmd.wr_split = 1'b1;
				state_d      = S_IDLE;
			end
			S_FCHK: begin
				if (stat.free_bad) begin
					cmd.emit = 1'b1;
					cmd.st   = ffa_pkg::ST_BADADDR;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_FEV;
				end
			end
			S_FEV: begin
				cmd.emit = 1'b1;
				if (stat.present) begin
					cmd.wr_free = 1'b1;
					cmd.st      = ffa_pkg::ST_DONE;
				end else begin
					cmd.st = ffa_pkg::ST_BADADDR;
				end
				state_d = S_IDLE;
			end
			S_RST: begin
				cmd.clear = 1'b1;
				cmd.emit  = 1'b1;
				cmd.st    = ffa_pkg::ST_DONE;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== src/ffa_datapath.sv =====
// Datapath of the first-fit block allocator: header memory, walk pointer, result registers.
// Depends on ffa_pkg; driven by ffa_ctrl.
`default_nettype none
module ffa_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ffa_pkg::cmd_t              cmd,
	input  wire logic [ffa_pkg::KIND_W-1:0] kind,
	input  wire logic [ffa_pkg::REQ_W-1:0]  request_bytes,
	input  wire logic [ffa_pkg::OFF_W-1:0]  free_offset,
	output ffa_pkg::stat_t                  stat,
	output logic                            done,
	output logic [ffa_pkg::ST_W-1:0]        status,
	output logic [ffa_pkg::OFF_W-1:0]       data_offset,
	output logic [ffa_pkg::OFF_W-1:0]       granted_bytes
);

	localparam int GW = ffa_pkg::GW;
	localparam int PW = ffa_pkg::PW;
	localparam int CW = ffa_pkg::CW;

	// header store; valid bits make unwritten entries read as after restart
	ffa_pkg::entry_t       mem [ffa_pkg::NGRAN];
	logic [ffa_pkg::NGRAN-1:0] valid_q;

	ffa_pkg::entry_t       rd_q;
	logic                  rd_vld_q;
	logic                  rd_zero_q;
	logic [GW:0]           g_q;
	logic [PW-1:0]         pad_q;
	logic [ffa_pkg::OFF_W-1:0] off_q;
	logic [GW-1:0]         spl_addr_q;
	ffa_pkg::entry_t       spl_data_q;

	logic                  done_q;
	logic [ffa_pkg::ST_W-1:0]  status_q;
	logic [ffa_pkg::OFF_W-1:0] data_offset_q;
	logic [ffa_pkg::OFF_W-1:0] granted_q;

	ffa_pkg::entry_t       ent;
	logic [CW-1:0]         size_c, pad_c, g_c, ng_c, next_c;
	logic [GW-1:0]         keep_size, rem_size;
	logic [ffa_pkg::OFF_W-1:0] fdiff, fgran;
	logic [16:0]           pad_sum;
	logic [GW-1:0]         raddr, waddr;
	ffa_pkg::entry_t       wdata;
	logic                  wr_en, rd_en;
	logic [31:0]           data_byte, grant_byte;

	// entry under evaluation
	always_comb begin
		if (rd_vld_q)
			ent = rd_q;
		else if (rd_zero_q)
			ent = ffa_pkg::ENTRY_ARENA;
		else
			ent = ffa_pkg::ENTRY_ABSENT;
	end

	// fit, split and next-block arithmetic in granules
	assign size_c    = CW'(ent.size);
	assign pad_c     = CW'(pad_q);
	assign g_c       = CW'(g_q);
	assign next_c    = g_c + CW'(ffa_pkg::HDR_G) + size_c;
	assign ng_c      = g_c + CW'(ffa_pkg::HDR_G) + pad_c;
	assign keep_size = stat.split_ok ? pad_q[GW-1:0] : ent.size;
	assign rem_size  = GW'(size_c - pad_c - CW'(ffa_pkg::HDR_G));

	assign stat.present  = ent.present;
	assign stat.fits     = !ent.used && (size_c >= pad_c);
	assign stat.split_ok = (size_c >= pad_c + CW'(2 * ffa_pkg::HDR_G)) &&
		(ng_c < CW'(ffa_pkg::NGRAN));
	assign stat.next_oob = (next_c >= CW'(ffa_pkg::NGRAN));

	// free address decode
	assign fdiff = free_offset - ffa_pkg::OFF_W'(ffa_pkg::HDR_BYTES);
	assign fgran = fdiff >> ffa_pkg::ALIGN_LOG2;
	assign stat.free_bad = (off_q < ffa_pkg::OFF_W'(ffa_pkg::HDR_BYTES)) ||
		(off_q[ffa_pkg::ALIGN_LOG2-1:0] != '0) ||
		(((off_q - ffa_pkg::OFF_W'(ffa_pkg::HDR_BYTES)) >> ffa_pkg::ALIGN_LOG2) >=
		ffa_pkg::OFF_W'(ffa_pkg::NGRAN));

	// request rounded up to whole granules
	assign pad_sum = 17'(request_bytes) + 17'(ffa_pkg::ALIGN_BYTES - 1);

	// memory port selection
	assign rd_en = cmd.rd_cur || cmd.step;
	assign raddr = cmd.step ? next_c[GW-1:0] : g_q[GW-1:0];
	assign wr_en = cmd.wr_grant || cmd.wr_split || cmd.wr_free;

	always_comb begin
		waddr = g_q[GW-1:0];
		wdata = '{present: 1'b1, used: 1'b0, size: ent.size};
		if (cmd.wr_grant)
			wdata = '{present: 1'b1, used: 1'b1, size: keep_size};
		else if (cmd.wr_split) begin
			waddr = spl_addr_q;
			wdata = spl_data_q;
		end
	end

	// header memory
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[waddr] <= wdata;
		if (rd_en)
			rd_q <= mem[raddr];
	end

	// valid bits and read tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_q  <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			if (cmd.clear)
				valid_q <= '0;
			else if (wr_en)
				valid_q[waddr] <= 1'b1;
			if (rd_en) begin
				rd_vld_q  <= valid_q[raddr];
				rd_zero_q <= (raddr == '0);
			end
		end
	end

	// item capture, walk pointer and split hold
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pad_q <= pad_sum[16:ffa_pkg::ALIGN_LOG2];
			off_q <= free_offset;
			g_q   <= (kind == ffa_pkg::KIND_FREE) ? (GW+1)'(fgran) : '0;
		end else if (cmd.step) begin
			g_q <= next_c[GW:0];
		end
		if (cmd.wr_grant) begin
			spl_addr_q <= ng_c[GW-1:0];
			spl_data_q <= '{present: 1'b1, used: 1'b0, size: rem_size};
		end
	end

	// result values
	assign data_byte  = (32'(g_q) + 32'(ffa_pkg::HDR_G)) << ffa_pkg::ALIGN_LOG2;
	assign grant_byte = 32'(keep_size) << ffa_pkg::ALIGN_LOG2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.st;
			if (cmd.wr_grant) begin
				data_offset_q <= data_byte[ffa_pkg::OFF_W-1:0];
				granted_q     <= grant_byte[ffa_pkg::OFF_W-1:0];
			end else begin
				data_offset_q <= '0;
				granted_q     <= '0;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign data_offset   = data_offset_q;
	assign granted_bytes = granted_q;

endmodule
`default_nettype wire

// ===== src/first_fit_block_allocator.sv =====
// First-fit block allocator: an allocate walks one block header per cycle; the
// result strobes once the walk has examined between 1 and 64 blocks.
// A split keeps busy through its header write; free checks the address, then reads the header.
// One item at a time; the next start is taken once busy falls. done is a one-cycle strobe.
// Reset (asynchronous, arst_n low) leaves the arena as one free block at once.
// Depends on ffa_pkg, ffa_ctrl, ffa_datapath and the assertion header.
`default_nettype none
`include "first_fit_block_allocator_assert.svh"
module first_fit_block_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [ffa_pkg::KIND_W-1:0] kind,
	input  wire logic [ffa_pkg::REQ_W-1:0]  request_bytes,
	input  wire logic [ffa_pkg::OFF_W-1:0]  free_offset,
	output logic                            done,
	output logic [ffa_pkg::ST_W-1:0]        status,
	output logic [ffa_pkg::OFF_W-1:0]       data_offset,
	output logic [ffa_pkg::OFF_W-1:0]       granted_bytes
);

	ffa_pkg::cmd_t  cmd;
	ffa_pkg::stat_t stat;

	// sequencing
	ffa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// storage and arithmetic
	ffa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.kind          (kind),
		.request_bytes (request_bytes),
		.free_offset   (free_offset),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.data_offset   (data_offset),
		.granted_bytes (granted_bytes)
	);

	// checks
	`FFA_ASSERT_NXT(a_start_busy, start && !busy, busy || done)
	`FFA_ASSERT_IMP(a_done_after_busy, done, $past(busy))
	`FFA_ASSERT_IMP(a_fail_zero, done && (status != ffa_pkg::ST_DONE), (data_offset == '0) && (granted_bytes == '0))
	`FFA_ASSERT_IMP(a_one_result, done, !$past(done) || $past(busy))

endmodule
`default_nettype wire

// ===== tb/ffa_reply_checker.sv =====
// Result checker for the first-fit block allocator: keeps its own copy of the arena
// headers, predicts each reply and compares it with the strobed result.
// Depends on ffa_pkg for port widths, geometry and status codes.
module ffa_reply_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [ffa_pkg::KIND_W-1:0] kind,
	input  logic [ffa_pkg::REQ_W-1:0]  request_bytes,
	input  logic [ffa_pkg::OFF_W-1:0]  free_offset,
	input  logic                       done,
	input  logic [ffa_pkg::ST_W-1:0]   status,
	input  logic [ffa_pkg::OFF_W-1:0]  data_offset,
	input  logic [ffa_pkg::OFF_W-1:0]  granted_bytes,
	output int                         mismatches,
	output int                         outstanding,
	output int                         compared
);
	timeunit 1ns;
	timeprecision 1ps;
	import ffa_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [OFF_W-1:0] offset;
		logic [OFF_W-1:0] granted;
	} arena_reply_t;

	// shadow copy of the block headers, one slot per granule
	bit          blk_present [NGRAN];
	bit          blk_used    [NGRAN];
	int unsigned blk_bytes   [NGRAN];

	arena_reply_t arena_replies[$];

	// whole arena back to one free block
	function automatic void reset_arena();
		for (int g = 0; g < NGRAN; g++) begin
			blk_present[g] = 1'b0;
			blk_used[g]    = 1'b0;
			blk_bytes[g]   = 0;
		end
		blk_present[0] = 1'b1;
		blk_bytes[0]   = ARENA_BYTES - HDR_BYTES;
	endfunction

	// apply one command to the shadow arena and return the reply it should give
	function automatic arena_reply_t apply_to_arena(logic [KIND_W-1:0] k,
			logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
		arena_reply_t r;
		int unsigned  pad, pos, g, data, ng, hpos;
		r = '0;
		case (k)
			KIND_ALLOC: begin
				pad = ((int'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
				r.status = ST_NOSPACE;
				pos = 0;
				// first fit: walk blocks in address order
				while (pos < ARENA_BYTES) begin
					g = pos / ALIGN_BYTES;
					if (!blk_present[g])
						break;
					if (!blk_used[g] && blk_bytes[g] >= pad) begin
						data = pos + HDR_BYTES;
						// split when the rest can hold a header and more
						if (blk_bytes[g] >= pad + 2 * HDR_BYTES) begin
							ng = (data + pad) / ALIGN_BYTES;
							if (ng < NGRAN) begin
								blk_present[ng] = 1'b1;
								blk_used[ng]    = 1'b0;
								blk_bytes[ng]   = blk_bytes[g] - pad - HDR_BYTES;
								blk_bytes[g]    = pad;
							end
						end
						blk_used[g] = 1'b1;
						r.status    = ST_DONE;
						r.offset    = OFF_W'(data);
						r.granted   = OFF_W'(blk_bytes[g]);
						break;
					end
					pos += HDR_BYTES + blk_bytes[g];
				end
			end
			KIND_FREE: begin
				r.status = ST_BADADDR;
				if (off >= HDR_BYTES) begin
					hpos = int'(off) - HDR_BYTES;
					g    = hpos / ALIGN_BYTES;
					if (hpos % ALIGN_BYTES == 0 && g < NGRAN && blk_present[g]) begin
						blk_used[g] = 1'b0;
						r.status    = ST_DONE;
					end
				end
			end
			default: begin
				// restart and the spare kind alike
				reset_arena();
				r.status = ST_DONE;
			end
		endcase
		return r;
	endfunction

	// results first, then the new command, so a same-edge pair stays in order
	always @(posedge clk or negedge arst_n) begin
		arena_reply_t want;
		if (!arst_n) begin
			reset_arena();
			arena_replies.delete();
			mismatches  = 0;
			outstanding = 0;
			compared    = 0;
		end else begin
			if (done) begin
				if (arena_replies.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] unexpected result: status %0d offset %0d bytes %0d",
							$time, status, data_offset, granted_bytes);
					mismatches++;
				end else begin
					want = arena_replies.pop_front();
					compared++;
					if (want.status !== status || want.offset !== data_offset ||
							want.granted !== granted_bytes) begin
						if (mismatches < 10)
							$display({"[%0t] result mismatch (expected/actual): ",
								"status %0d/%0d offset %0d/%0d bytes %0d/%0d"}, $time,
								want.status, status, want.offset, data_offset,
								want.granted, granted_bytes);
						mismatches++;
					end
				end
			end
			if (start && !busy)
				arena_replies.push_back(apply_to_arena(kind, request_bytes, free_offset));
			outstanding = arena_replies.size();
		end
	end

endmodule

// ===== tb/first_fit_block_allocator_tb.sv =====
// Testbench top for the first-fit block allocator: clock, reset, command stimulus
// and the verdict. Depends on ffa_pkg, the allocator RTL and ffa_reply_checker.
module first_fit_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffa_pkg::*;

	localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;
	localparam int RANDOM_ITEMS    = 1000;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int SETTLE_CYCLES   = 80;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [KIND_W-1:0]  kind;
	logic [REQ_W-1:0]   request_bytes;
	logic [OFF_W-1:0]   free_offset;
	logic               done;
	logic [ST_W-1:0]    status;
	logic [OFF_W-1:0]   data_offset;
	logic [OFF_W-1:0]   granted_bytes;

	int mismatches, outstanding, compared;
	int n_alloc, n_free, n_restart;
	int stalled;

	// data offsets handed out and not yet given back by the stimulus
	logic [OFF_W-1:0] live_offsets[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	first_fit_block_allocator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.request_bytes (request_bytes),
		.free_offset   (free_offset),
		.done          (done),
		.status        (status),
		.data_offset   (data_offset),
		.granted_bytes (granted_bytes)
	);

	ffa_reply_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.request_bytes (request_bytes),
		.free_offset   (free_offset),
		.done          (done),
		.status        (status),
		.data_offset   (data_offset),
		.granted_bytes (granted_bytes),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.compared      (compared)
	);

	// remember grants so that most frees hit a real block
	always @(posedge clk) begin
		if (arst_n && done && status == ST_DONE && data_offset != '0)
			live_offsets.push_back(data_offset);
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stalled <= 0;
		end else begin
			stalled <= stalled + 1;
			if (stalled >= WATCHDOG_CYCLES) begin
				$display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// one command transfer; start is left high for the caller to reuse or drop
	task automatic issue(input logic [KIND_W-1:0] k, input logic [REQ_W-1:0] req,
			input logic [OFF_W-1:0] off);
		@(negedge clk);
		start         <= 1'b1;
		kind          <= k;
		request_bytes <= req;
		free_offset   <= off;
		do
			@(posedge clk);
		while (busy);
		case (k)
			KIND_ALLOC: n_alloc++;
			KIND_FREE:  n_free++;
			default:    n_restart++;
		endcase
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic drain();
		hold_off(1);
		wait (outstanding == 0);
	endtask

	initial begin
		int                sel, idx;
		logic [REQ_W-1:0]  req;
		logic [OFF_W-1:0]  off;
		arst_n        = 1'b0;
		start         = 1'b0;
		kind          = KIND_ALLOC;
		request_bytes = '0;
		free_offset   = '0;
		n_alloc       = 0;
		n_free        = 0;
		n_restart     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: whole arena, exhaustion, bad frees, splits and exact fits
		issue(KIND_ALLOC, 16'd1008, '0);
		issue(KIND_ALLOC, 16'd0, '0);
		issue(KIND_FREE, '0, 10'd16);
		issue(KIND_FREE, '0, 10'd16);      // block already free
		issue(KIND_FREE, '0, 10'd0);       // below one header
		issue(KIND_FREE, '0, 10'd24);      // off granule
		issue(KIND_FREE, '0, 10'd32);      // no header there
		issue(KIND_FREE, '0, 10'd1023);
		issue(KIND_SPARE, 16'hFFFF, 10'h3FF);
		issue(KIND_ALLOC, 16'd0, '0);      // zero request, split
		issue(KIND_ALLOC, 16'hFFFF, '0);   // rounds past the arena
		issue(KIND_ALLOC, 16'd1, '0);
		issue(KIND_ALLOC, 16'd17, '0);
		issue(KIND_FREE, '0, 10'd48);
		issue(KIND_ALLOC, 16'd5, '0);      // 48 held no header, so this walks past the used blocks
		issue(KIND_FREE, '0, 10'd16);
		issue(KIND_ALLOC, 16'd0, '0);      // zero-size block fits zero
		issue(KIND_RESTART, '0, '0);
		issue(KIND_ALLOC, 16'd976, '0);    // split leaves exactly one granule
		issue(KIND_ALLOC, 16'd16, '0);     // last data offset in the arena
		issue(KIND_ALLOC, 16'd0, '0);
		issue(KIND_FREE, '0, 10'd1008);
		issue(KIND_RESTART, '0, '0);
		issue(KIND_ALLOC, 16'd977, '0);    // too short to split
		issue(KIND_RESTART, '0, '0);
		drain();
		live_offsets.delete();

		// random: mostly small allocates and frees of live blocks
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (!(i >= 300 && i < 500) && $urandom_range(99) < 17)
				hold_off($urandom_range(1, 4));
			if (i == 600)
				drain();
			sel = $urandom_range(99);
			if (sel < 3) begin
				live_offsets.delete();
				issue($urandom_range(1) ? KIND_RESTART : KIND_SPARE, REQ_W'($urandom),
					OFF_W'($urandom));
			end else if (sel < 52) begin
				sel = $urandom_range(99);
				if (sel < 70)
					req = REQ_W'($urandom_range(0, 96));
				else if (sel < 90)
					req = REQ_W'($urandom_range(97, 1008));
				else
					req = REQ_W'($urandom);
				issue(KIND_ALLOC, req, OFF_W'($urandom));
			end else begin
				sel = $urandom_range(99);
				if (sel < 60 && live_offsets.size() > 0) begin
					idx = $urandom_range(live_offsets.size() - 1);
					off = live_offsets[idx];
					live_offsets.delete(idx);
				end else if (sel < 85) begin
					off = OFF_W'($urandom_range(1, NGRAN - 1) * ALIGN_BYTES);
				end else begin
					off = OFF_W'($urandom_range(0, 1023));
				end
				issue(KIND_FREE, REQ_W'($urandom), off);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d allocates, %0d frees and %0d restarts;", n_alloc, n_free,
			n_restart);
		$display("%0d results compared, %0d mismatching.", compared, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
